// ----- hw/rtl/ptmt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptmt_pkg: shared types and constants for the page table translate core
// Entry layout, request and status codes, register map and reset values.
// ----------------------------------------------------------------------------
package ptmt_pkg;

  localparam int DEF_PAGE_BITS = 12;
  localparam int DEF_NUM_PAGES = 1024;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam logic [31:0] RST_PHYS_BASE = 32'h0000_0000;
  localparam logic [7:0]  RST_WRITE_MASK = 8'h02;
  localparam logic [7:0]  RST_USER_MASK  = 8'h04;

  typedef enum logic [1:0] {
    REG_PHYS_BASE  = 2'd0,
    REG_WRITE_MASK = 2'd1,
    REG_USER_MASK  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    REQ_MAP   = 3'd0,
    REQ_UNMAP = 3'd1,
    REQ_XLATE = 3'd2,
    REQ_ALLOC = 3'd3,
    REQ_FREE  = 3'd4,
    REQ_PROT  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] frame;
    logic        present;
    logic        writable;
    logic        user;
  } pte_t;

  typedef struct packed {
    logic [31:0] op_a;
    logic [31:0] op_b;
  } alu_req_t;

endpackage

// ----- hw/rtl/page_table_map_translate_core.sv -----
// ----------------------------------------------------------------------------
// page_table_map_translate_core: single-level page table with range requests
// One request at a time; the next is taken the cycle after the result loads,
// and a stalled result holds the final step. After reset a clearing pass
// zeroes the table while requests stall; config writes are taken anytime.
// ----------------------------------------------------------------------------
module page_table_map_translate_core #(
  parameter int PAGE_BITS = ptmt_pkg::DEF_PAGE_BITS,
  parameter int NUM_PAGES = ptmt_pkg::DEF_NUM_PAGES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptmt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // request beats
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic [31:0]                  virt_addr_i,
  input  logic [31:0]                  phys_addr_i,
  input  logic [31:0]                  region_size_i,
  input  logic                         write_ok_i,
  input  logic                         user_ok_i,
  input  logic [7:0]                   prot_flags_i,
  // result beats
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [31:0]                  result_addr_o
);
  import ptmt_pkg::*;

  localparam int AddrW = $clog2(NUM_PAGES);

  // --------------------------------------------------------------------------
  // Configuration registers. Registers sit at byte offsets 0, 4 and 8; the
  // word index is paddr[3:2]. Writes to unused offsets are dropped.
  // --------------------------------------------------------------------------
  logic [31:0] phys_base_q;
  logic [7:0]  write_mask_q;
  logic [7:0]  user_mask_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phys_base_q  <= RST_PHYS_BASE;
      write_mask_q <= RST_WRITE_MASK;
      user_mask_q  <= RST_USER_MASK;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PHYS_BASE:  phys_base_q  <= pwdata;
        REG_WRITE_MASK: write_mask_q <= pwdata[7:0];
        REG_USER_MASK:  user_mask_q  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PHYS_BASE:  prdata = phys_base_q;
      REG_WRITE_MASK: prdata = {24'd0, write_mask_q};
      REG_USER_MASK:  prdata = {24'd0, user_mask_q};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath: sequencer drives one shared adder and the single-port table.
  // --------------------------------------------------------------------------
  alu_req_t         alu_req;
  logic [31:0]      alu_sum;
  logic             tbl_we;
  logic             tbl_re;
  logic [AddrW-1:0] tbl_addr;
  pte_t             tbl_wdata;
  pte_t             tbl_rdata;

  ptmt_seq #(
    .PAGE_BITS (PAGE_BITS),
    .NUM_PAGES (NUM_PAGES)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .virt_addr_i       (virt_addr_i),
    .phys_addr_i       (phys_addr_i),
    .region_size_i     (region_size_i),
    .write_ok_i        (write_ok_i),
    .user_ok_i         (user_ok_i),
    .prot_flags_i      (prot_flags_i),
    .phys_base_i       (phys_base_q),
    .write_flag_mask_i (write_mask_q),
    .user_flag_mask_i  (user_mask_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .result_addr_o     (result_addr_o),
    .alu_req_o         (alu_req),
    .alu_sum_i         (alu_sum),
    .tbl_we_o          (tbl_we),
    .tbl_re_o          (tbl_re),
    .tbl_addr_o        (tbl_addr),
    .tbl_wdata_o       (tbl_wdata),
    .tbl_rdata_i       (tbl_rdata)
  );

  ptmt_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  ptmt_table #(
    .NUM_PAGES (NUM_PAGES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .re_i    (tbl_re),
    .addr_i  (tbl_addr),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

endmodule

// ----- hw/rtl/ptmt_alu.sv -----
// ----------------------------------------------------------------------------
// ptmt_alu: shared 32-bit adder
// Serves range end, first frame, per-page frame step and frame plus offset.
// ----------------------------------------------------------------------------
module ptmt_alu (
  input  ptmt_pkg::alu_req_t req_i,
  output logic [31:0]        sum_o
);
  import ptmt_pkg::*;

  // wraps to 32 bits by design
  assign sum_o = req_i.op_a + req_i.op_b;

endmodule

// ----- hw/rtl/ptmt_table.sv -----
// ----------------------------------------------------------------------------
// ptmt_table: page table storage
// Single-port RAM, one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ptmt_table #(
  parameter int NUM_PAGES = ptmt_pkg::DEF_NUM_PAGES
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic                         re_i,
  input  logic [$clog2(NUM_PAGES)-1:0] addr_i,
  input  ptmt_pkg::pte_t               wdata_i,
  output ptmt_pkg::pte_t               rdata_o
);
  import ptmt_pkg::*;

  pte_t mem [NUM_PAGES];
  pte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ptmt_seq.sv -----
// ----------------------------------------------------------------------------
// ptmt_seq: request sequencer
// Steps one request through table accesses and the shared adder, walking
// range requests page by page, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ptmt_seq #(
  parameter int PAGE_BITS = ptmt_pkg::DEF_PAGE_BITS,
  parameter int NUM_PAGES = ptmt_pkg::DEF_NUM_PAGES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic [31:0]                  virt_addr_i,
  input  logic [31:0]                  phys_addr_i,
  input  logic [31:0]                  region_size_i,
  input  logic                         write_ok_i,
  input  logic                         user_ok_i,
  input  logic [7:0]                   prot_flags_i,
  // configuration
  input  logic [31:0]                  phys_base_i,
  input  logic [7:0]                   write_flag_mask_i,
  input  logic [7:0]                   user_flag_mask_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [31:0]                  result_addr_o,
  // shared adder
  output ptmt_pkg::alu_req_t           alu_req_o,
  input  logic [31:0]                  alu_sum_i,
  // table port
  output logic                         tbl_we_o,
  output logic                         tbl_re_o,
  output logic [$clog2(NUM_PAGES)-1:0] tbl_addr_o,
  output ptmt_pkg::pte_t               tbl_wdata_o,
  input  ptmt_pkg::pte_t               tbl_rdata_i
);
  import ptmt_pkg::*;

  localparam int VpnW    = 32 - PAGE_BITS;
  localparam int CntBits = VpnW + 1;
  localparam int AddrW   = $clog2(NUM_PAGES);
  localparam int CntW    = (CntBits > AddrW + 1) ? CntBits : AddrW + 1;
  localparam logic [CntW-1:0] NumPg  = CntW'(NUM_PAGES);
  localparam logic [CntW-1:0] LastPg = CntW'(NUM_PAGES - 1);
  localparam logic [31:0] PageStep   = 32'(1) << PAGE_BITS;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_END,
    S_XRD,
    S_FRAME,
    S_WALK,
    S_PRD,
    S_PCHK,
    S_FIN
  } state_e;

  state_e        state_q;
  logic [2:0]    req_q;
  logic [31:0]   va_q;
  logic [31:0]   pa_q;
  logic          wok_q;
  logic          uok_q;
  logic          wflag_q;
  logic          uflag_q;
  logic [CntBits-1:0] cnt_q;
  logic [CntW-1:0] end_q;
  logic [CntW-1:0] idx_q;
  logic [31:0]   frame_q;
  status_e       st_q;
  logic [31:0]   res_q;
  logic          out_valid_q;
  status_e       out_status_q;
  logic [31:0]   out_res_q;

  logic [CntW-1:0] start_w;
  logic [CntW-1:0] addr_cw;
  logic            start_in;
  logic            walk_go;
  logic            accept;
  logic            out_fire;

  assign start_w  = CntW'(va_q[31:PAGE_BITS]);
  assign start_in = start_w < NumPg;
  assign walk_go  = (idx_q < end_q) && (idx_q < NumPg);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_addr_o = out_res_q;
  assign tbl_addr_o    = addr_cw[AddrW-1:0];

  // adder operands and table port per step
  always_comb begin
    alu_req_o   = '0;
    tbl_we_o    = 1'b0;
    tbl_re_o    = 1'b0;
    addr_cw     = idx_q;
    tbl_wdata_o = '0;
    unique case (state_q)
      S_CLEAR: begin
        tbl_we_o = 1'b1;
      end
      S_END: begin
        alu_req_o.op_a = 32'(start_w);
        alu_req_o.op_b = 32'(cnt_q);
        addr_cw        = start_w;
        if (req_q == REQ_MAP) begin
          tbl_we_o    = start_in;
          tbl_wdata_o = '{frame: pa_q, present: 1'b1, writable: wok_q, user: uok_q};
        end else if (req_q == REQ_UNMAP) begin
          tbl_we_o = start_in;
        end else if (req_q == REQ_XLATE) begin
          tbl_re_o = start_in;
        end
      end
      S_XRD: begin
        alu_req_o.op_a = tbl_rdata_i.frame;
        alu_req_o.op_b = 32'(va_q[PAGE_BITS-1:0]);
      end
      S_FRAME: begin
        alu_req_o.op_a = phys_base_i;
        alu_req_o.op_b = {va_q[31:PAGE_BITS], {PAGE_BITS{1'b0}}};
      end
      S_WALK: begin
        alu_req_o.op_a = frame_q;
        alu_req_o.op_b = PageStep;
        tbl_we_o       = walk_go;
        if (req_q == REQ_ALLOC) begin
          tbl_wdata_o = '{frame: frame_q, present: 1'b1, writable: wok_q, user: uok_q};
        end
      end
      S_PRD: begin
        tbl_re_o = walk_go;
      end
      S_PCHK: begin
        tbl_we_o    = tbl_rdata_i.present;
        tbl_wdata_o = '{frame: tbl_rdata_i.frame, present: 1'b1,
                        writable: wflag_q, user: uflag_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the final step reloads the result register itself
      if (out_fire && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (idx_q == LastPg) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_q   <= req_type_i;
            va_q    <= virt_addr_i;
            pa_q    <= phys_addr_i;
            wok_q   <= write_ok_i;
            uok_q   <= user_ok_i;
            wflag_q <= |(prot_flags_i & write_flag_mask_i);
            uflag_q <= |(prot_flags_i & user_flag_mask_i);
            // ceil(size / page size)
            cnt_q   <= CntBits'(region_size_i[31:PAGE_BITS]) +
                       CntBits'(|region_size_i[PAGE_BITS-1:0]);
            state_q <= S_END;
          end
        end
        S_END: begin
          end_q <= alu_sum_i[CntW-1:0];
          idx_q <= start_w;
          res_q <= '0;
          // single-page requests fault here when the page is off the table
          if (!start_in &&
              (req_q == REQ_MAP || req_q == REQ_UNMAP || req_q == REQ_XLATE)) begin
            st_q <= ST_RANGE;
          end else begin
            st_q <= ST_OK;
          end
          unique case (req_q)
            REQ_MAP, REQ_UNMAP: state_q <= S_FIN;
            REQ_XLATE: state_q <= start_in ? S_XRD : S_FIN;
            REQ_ALLOC: state_q <= S_FRAME;
            REQ_FREE:  state_q <= S_WALK;
            REQ_PROT:  state_q <= S_PRD;
            default:   state_q <= S_FIN;
          endcase
        end
        S_XRD: begin
          if (tbl_rdata_i.present) begin
            res_q <= alu_sum_i;
          end else begin
            st_q <= ST_ABSENT;
          end
          state_q <= S_FIN;
        end
        S_FRAME: begin
          frame_q <= alu_sum_i;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (walk_go) begin
            idx_q   <= idx_q + 1'b1;
            frame_q <= alu_sum_i;
          end else begin
            if (req_q == REQ_ALLOC) begin
              if ((end_q > NumPg) && (cnt_q != '0)) begin
                st_q <= ST_RANGE;
              end else begin
                res_q <= va_q;
              end
            end
            state_q <= S_FIN;
          end
        end
        S_PRD: begin
          priority if (idx_q >= end_q) begin
            state_q <= S_FIN;
          end else if (idx_q >= NumPg) begin
            st_q    <= ST_RANGE;
            state_q <= S_FIN;
          end else begin
            state_q <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (!tbl_rdata_i.present) begin
            st_q    <= ST_ABSENT;
            state_q <= S_FIN;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_PRD;
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= st_q;
            out_res_q    <= res_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // table writes stay inside the table
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we_o |-> (addr_cw < NumPg))
    else $error("table write outside table");

  // a range walk never passes its end page
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_PRD || state_q == S_PCHK) |-> (idx_q <= end_q))
    else $error("walk index past range end");

  // a new result only comes out of the final step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(out_valid_q) && out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result loaded outside final step");

endmodule

// ----- sim/page_table_map_translate_core_tb.sv -----
// ----------------------------------------------------------------------------
// page_table_map_translate_core_tb: self-checking bench for the page table core
// Drives map/unmap/translate and the range requests (allocate, free, protect)
// through the valid/stall request port, predicts every result beat with a
// local copy of the page table and the three config registers, and compares
// status and address beat by beat. Config goes in over the APB port between
// phases, with a read-back of each register.
// ----------------------------------------------------------------------------
module page_table_map_translate_core_tb;
  import ptmt_pkg::*;

  localparam int PAGE_BITS = DEF_PAGE_BITS;
  localparam int NUM_PAGES = DEF_NUM_PAGES;
  localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_BITS;
  localparam logic [31:0] OFFSET_MASK = 32'((64'd1 << PAGE_BITS) - 64'd1);
  // request codes the core has to ignore
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;
  // pages most random traffic lands on, so maps and walks overlap
  localparam int HOT_PAGES = 32;
  localparam int SETTLE_CYCLES = 32;
  // worst case: ~760 beats, each a 1024-page protect walk plus both idle bursts
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0]  req;
    logic [31:0] va;
    logic [31:0] pa;
    logic [31:0] size;
    logic        wr;
    logic        usr;
    logic [7:0]  prot;
  } pt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } pt_resp_t;

  // DUT signals; every input is known from time zero
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [2:0]          req_type_i = '0;
  logic [31:0]         virt_addr_i = '0;
  logic [31:0]         phys_addr_i = '0;
  logic [31:0]         region_size_i = '0;
  logic                write_ok_i = 1'b0;
  logic                user_ok_i = 1'b0;
  logic [7:0]          prot_flags_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          status_o;
  logic [31:0]         result_addr_o;

  // shadow of the table and registers
  logic [31:0] pt_frame   [NUM_PAGES];
  logic        pt_present [NUM_PAGES];
  logic        pt_write   [NUM_PAGES];
  logic        pt_user    [NUM_PAGES];
  logic [31:0] cfg_phys_base = RST_PHYS_BASE;
  logic [7:0]  cfg_write_mask = RST_WRITE_MASK;
  logic [7:0]  cfg_user_mask = RST_USER_MASK;

  pt_resp_t pending_rsp_q[$];
  pt_resp_t want_rsp;
  int       err_count = 0;
  int       sent_count = 0;
  int       rsp_count = 0;
  int       cycle_count = 0;
  int       stall_left = 0;
  bit       idle_on = 1'b1;

  page_table_map_translate_core #(
    .PAGE_BITS(PAGE_BITS),
    .NUM_PAGES(NUM_PAGES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .virt_addr_i  (virt_addr_i),
    .phys_addr_i  (phys_addr_i),
    .region_size_i(region_size_i),
    .write_ok_i   (write_ok_i),
    .user_ok_i    (user_ok_i),
    .prot_flags_i (prot_flags_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .result_addr_o(result_addr_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Global watchdog: a hung walk or a lost beat ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Page table prediction. Page numbers and counts are held in 64 bits so the
  // size round-up and the range end never wrap.
  // --------------------------------------------------------------------------
  function automatic pt_resp_t table_apply(input pt_req_t r);
    pt_resp_t    rsp;
    logic [63:0] first_pg;
    logic [63:0] n_pages;
    logic [63:0] end_pg;
    logic [63:0] stop_pg;
    logic [63:0] pg;
    logic [63:0] offs;
    rsp.status = ST_OK;
    rsp.addr = '0;
    first_pg = {32'd0, r.va} >> PAGE_BITS;
    n_pages = ({32'd0, r.size} + PAGE_BYTES - 64'd1) >> PAGE_BITS;
    end_pg = first_pg + n_pages;
    stop_pg = (end_pg < NUM_PAGES) ? end_pg : 64'(NUM_PAGES);
    case (r.req)
      REQ_MAP: begin
        if (first_pg >= NUM_PAGES) begin
          rsp.status = ST_RANGE;
        end else begin
          pt_frame[int'(first_pg)] = r.pa;
          pt_present[int'(first_pg)] = 1'b1;
          pt_write[int'(first_pg)] = r.wr;
          pt_user[int'(first_pg)] = r.usr;
        end
      end
      REQ_UNMAP: begin
        if (first_pg >= NUM_PAGES) rsp.status = ST_RANGE;
        else pt_present[int'(first_pg)] = 1'b0;
      end
      REQ_XLATE: begin
        if (first_pg >= NUM_PAGES) rsp.status = ST_RANGE;
        else if (!pt_present[int'(first_pg)]) rsp.status = ST_ABSENT;
        else rsp.addr = pt_frame[int'(first_pg)] + (r.va & OFFSET_MASK);
      end
      REQ_ALLOC: begin
        for (pg = first_pg; pg < stop_pg; pg++) begin
          offs = pg << PAGE_BITS;
          pt_frame[int'(pg)] = cfg_phys_base + offs[31:0];
          pt_present[int'(pg)] = 1'b1;
          pt_write[int'(pg)] = r.wr;
          pt_user[int'(pg)] = r.usr;
        end
        // pages already mapped stay mapped when the range runs off the table
        if (end_pg > NUM_PAGES && n_pages != 0) rsp.status = ST_RANGE;
        else rsp.addr = r.va;
      end
      REQ_FREE: begin
        for (pg = first_pg; pg < stop_pg; pg++) pt_present[int'(pg)] = 1'b0;
      end
      REQ_PROT: begin
        // stops on the first bad page; earlier pages keep the new flags
        pg = first_pg;
        while (pg < end_pg && rsp.status == ST_OK) begin
          if (pg >= NUM_PAGES) begin
            rsp.status = ST_RANGE;
          end else if (!pt_present[int'(pg)]) begin
            rsp.status = ST_ABSENT;
          end else begin
            pt_write[int'(pg)] = (r.prot & cfg_write_mask) != 8'd0;
            pt_user[int'(pg)] = (r.prot & cfg_user_mask) != 8'd0;
            pg++;
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: one beat per call. Fields change only after acceptance, and
  // valid stays high into the next beat unless an idle burst is taken.
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [2:0] req, input logic [31:0] va, pa, size,
                          input logic [7:0] prot);
    pt_req_t item;
    item.req = req;
    item.va = va;
    item.pa = pa;
    item.size = size;
    item.wr = 1'($urandom_range(0, 1));
    item.usr = 1'($urandom_range(0, 1));
    item.prot = prot;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= item.req;
    virt_addr_i <= item.va;
    phys_addr_i <= item.pa;
    region_size_i <= item.size;
    write_ok_i <= item.wr;
    user_ok_i <= item.usr;
    prot_flags_i <= item.prot;
    do @(posedge clk_i); while (in_stall_o);
    pending_rsp_q.push_back(table_apply(item));
    sent_count++;
  endtask

  // Result side: random stall bursts while idling is on.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Every accepted result beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rsp_count++;
      if (pending_rsp_q.size() == 0) begin
        flag_error($sformatf("result beat %0d with nothing pending: status %0d addr %h",
                             rsp_count, status_o, result_addr_o));
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        if (status_o !== want_rsp.status)
          flag_error($sformatf("beat %0d status: expected %0d, got %0d",
                               rsp_count, want_rsp.status, status_o));
        if (result_addr_o !== want_rsp.addr)
          flag_error($sformatf("beat %0d result_addr: expected %h, got %h",
                               rsp_count, want_rsp.addr, result_addr_o));
      end
    end
  end

  // Stop sending and wait for the core to go quiet.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register; the bus is left
  // selected so the next transfer can follow directly.
  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PHYS_BASE: begin
        cfg_phys_base = val;
        if (prdata !== val)
          flag_error($sformatf("phys_base read: expected %h, got %h", val, prdata));
      end
      REG_WRITE_MASK: begin
        cfg_write_mask = val[7:0];
        if (prdata[7:0] !== val[7:0])
          flag_error($sformatf("write mask read: expected %h, got %h", val[7:0], prdata));
      end
      default: begin
        cfg_user_mask = val[7:0];
        if (prdata[7:0] !== val[7:0])
          flag_error($sformatf("user mask read: expected %h, got %h", val[7:0], prdata));
      end
    endcase
  endtask

  task automatic apply_config(input logic [31:0] base, input logic [7:0] wmask, umask);
    drain_results();
    cfg_write(REG_PHYS_BASE, base);
    cfg_write(REG_WRITE_MASK, {24'd0, wmask});
    cfg_write(REG_USER_MASK, {24'd0, umask});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random field pickers. Most addresses sit in a few hot pages so maps,
  // walks and translates hit each other; the rest spread over the table and
  // the whole 32-bit space.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] pick_va();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return (32'($urandom_range(0, HOT_PAGES - 1)) << PAGE_BITS) |
                       ($urandom & OFFSET_MASK);
    else if (r < 90) return $urandom & ((32'(NUM_PAGES) << PAGE_BITS) - 32'd1);
    else return $urandom;
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    else if (r < 80) return $urandom_range(1, 4 << PAGE_BITS);
    else if (r < 95) return $urandom_range(1, 64 << PAGE_BITS);
    else if (r < 98) return $urandom_range(1, NUM_PAGES << PAGE_BITS);
    else return $urandom;
  endfunction

  function automatic logic [2:0] pick_req();
    if ($urandom_range(0, 99) < 96) return 3'($urandom_range(REQ_MAP, REQ_PROT));
    else return $urandom_range(0, 1) ? REQ_RSVD6 : REQ_RSVD7;
  endfunction

  function automatic logic [31:0] same_page(input logic [31:0] va);
    return (va & ~OFFSET_MASK) | ($urandom & OFFSET_MASK);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Single-page map/unmap/translate, including the frame-plus-offset wrap and
  // every out-of-table case.
  task automatic test_single_page();
    send_req(REQ_XLATE, 32'h0000_0000, $urandom, $urandom, 8'h00);
    send_req(REQ_MAP,   32'h0000_0ABC, 32'hFFFF_F000, $urandom, 8'hFF);
    send_req(REQ_XLATE, 32'h0000_0FFF, $urandom, $urandom, 8'h00);
    send_req(REQ_MAP,   32'h0000_1000, 32'hFFFF_FFFF, $urandom, 8'h00);
    send_req(REQ_XLATE, 32'h0000_1FFF, $urandom, $urandom, 8'h00);   // sum wraps
    send_req(REQ_MAP,   32'h003F_FFFF, 32'h1234_5000, $urandom, 8'h00); // last page
    send_req(REQ_XLATE, 32'h003F_F000, $urandom, $urandom, 8'h00);
    send_req(REQ_MAP,   32'h0040_0000, $urandom, $urandom, 8'h00);   // first page past
    send_req(REQ_MAP,   32'hFFFF_FFFF, $urandom, $urandom, 8'h00);
    send_req(REQ_UNMAP, 32'hFFFF_FFFF, $urandom, $urandom, 8'h00);
    send_req(REQ_XLATE, 32'h0040_0000, $urandom, $urandom, 8'h00);
    send_req(REQ_UNMAP, 32'h0000_0000, $urandom, $urandom, 8'h00);
    send_req(REQ_XLATE, 32'h0000_0123, $urandom, $urandom, 8'h00);
  endtask

  // Range walks: empty ranges, partial allocate past the table end, protect
  // stopping on absent and out-of-table pages, full-size ranges, free beyond
  // the table, and the unused request codes.
  task automatic test_range_ops();
    send_req(REQ_ALLOC, 32'h0000_5123, $urandom, 32'h0000_0000, 8'h00);
    send_req(REQ_ALLOC, 32'h0001_0010, $urandom, 32'h0000_1001, 8'h00);
    send_req(REQ_XLATE, 32'h0001_1FFF, $urandom, $urandom, 8'h00);
    send_req(REQ_PROT,  32'h0001_0000, $urandom, 32'h0000_2000, 8'hFF);
    send_req(REQ_PROT,  32'h0001_0000, $urandom, 32'h0000_3000, 8'h00);
    send_req(REQ_ALLOC, 32'h003F_E800, $urandom, 32'h0000_3000, 8'h00);
    send_req(REQ_PROT,  32'h003F_E000, $urandom, 32'h0000_3000, 8'h00);
    send_req(REQ_ALLOC, 32'h0039_0000, $urandom, 32'hFFFF_FFFF, 8'h00);
    send_req(REQ_XLATE, 32'h003F_FABC, $urandom, $urandom, 8'h00);
    send_req(REQ_FREE,  32'h0039_0000, $urandom, 32'hFFFF_FFFF, 8'h00);
    send_req(REQ_XLATE, 32'h003F_FABC, $urandom, $urandom, 8'h00);
    send_req(REQ_FREE,  32'h0040_0000, $urandom, 32'h0000_2000, 8'h00);
    send_req(REQ_PROT,  32'hFFFF_F000, $urandom, 32'h0000_0000, 8'hFF);
    send_req(REQ_RSVD6, $urandom, $urandom, $urandom, 8'($urandom_range(0, 255)));
    send_req(REQ_RSVD7, $urandom, $urandom, $urandom, 8'($urandom_range(0, 255)));
  endtask

  // One random scenario: mostly well-formed sequences on random pages, plus
  // stray requests and protects over ranges that may have holes.
  task automatic run_scenario();
    logic [31:0] va;
    logic [31:0] size;
    int          pick;
    pick = $urandom_range(0, 99);
    va = pick_va();
    if (pick < 25) begin
      send_req(pick_req(), va, $urandom, pick_size(), 8'($urandom_range(0, 255)));
    end else if (pick < 50) begin
      send_req(REQ_MAP, va, $urandom, $urandom, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 3))
        send_req(REQ_XLATE, same_page(va), $urandom, $urandom, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) begin
        send_req(REQ_UNMAP, same_page(va), $urandom, $urandom, 8'($urandom_range(0, 255)));
        send_req(REQ_XLATE, same_page(va), $urandom, $urandom, 8'($urandom_range(0, 255)));
      end
    end else if (pick < 80) begin
      size = $urandom_range(1, 8 << PAGE_BITS);
      send_req(REQ_ALLOC, va, $urandom, size, 8'($urandom_range(0, 255)));
      repeat (2)
        send_req(REQ_XLATE, va + $urandom_range(0, size - 1), $urandom, $urandom,
                 8'($urandom_range(0, 255)));
      send_req(REQ_PROT, va, $urandom, size, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 40) begin
        send_req(REQ_FREE, va, $urandom, size, 8'($urandom_range(0, 255)));
        send_req(REQ_XLATE, va, $urandom, $urandom, 8'($urandom_range(0, 255)));
      end
    end else begin
      send_req(REQ_PROT, va, $urandom, pick_size(), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_mix(input int beats);
    int stop_at;
    stop_at = sent_count + beats;
    while (sent_count < stop_at) run_scenario();
  endtask

  initial begin
    for (int i = 0; i < NUM_PAGES; i++) begin
      pt_frame[i] = '0;
      pt_present[i] = 1'b0;
      pt_write[i] = 1'b0;
      pt_user[i] = 1'b0;
    end
    // Reset once; the core then clears its table while holding off requests.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_single_page();
    test_range_ops();
    // Register extremes, with allocate frames wrapping past 2^32.
    apply_config(32'hFFFF_F000, 8'hFF, 8'h00);
    test_random_mix(180);
    apply_config(32'h0000_0000, 8'h00, 8'hFF);
    test_random_mix(180);
    apply_config($urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    test_random_mix(170);
    // Last stretch runs with both sides always ready.
    idle_on = 1'b0;
    apply_config(32'hFFFF_FFFF, RST_WRITE_MASK, RST_USER_MASK);
    test_random_mix(170);
    drain_results();

    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
